// ===== hw/rtl/buddy_bitmap_free_coalesce_defines.svh =====
// assertion helpers included by the buddy_bitmap_free_coalesce rtl
`ifndef BUDDY_BITMAP_FREE_COALESCE_DEFINES_SVH
`define BUDDY_BITMAP_FREE_COALESCE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define BBFC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define BBFC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bbfc_pkg.sv =====
`timescale 1ns / 1ps

package bbfc_pkg;

    localparam int LAYER_W = 4;
    localparam int INDEX_W = 10;
    localparam int BYTE_W  = 8;

    typedef enum logic [1:0] {
        REQ_FREE = 2'd0,
        REQ_SET  = 2'd1,
        REQ_CLR  = 2'd2,
        REQ_TEST = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        ST_CLEAR = 2'd0,
        ST_IDLE  = 2'd1,
        ST_READ  = 2'd2,
        ST_EVAL  = 2'd3
    } state_t;

endpackage

// ===== hw/rtl/bbfc_ram.sv =====
`timescale 1ns / 1ps

module bbfc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/buddy_bitmap_free_coalesce.sv =====
`timescale 1ns / 1ps
// a rejected request shows its result in the cycle after start; set, clear and test
// pass through READ and EVAL once; a free repeats READ and EVAL per merged layer
// one transaction at a time, every buddy step is one read and one
// read-modify-write of the bitmap ram; busy drops in the cycle done shows
// reset: a clearing pass writes all 2^(MAX_LAYER-2) bytes (256 at the default) to
// zero, with busy held high; the receiver cannot stall, done lasts one cycle

`include "buddy_bitmap_free_coalesce_defines.svh"

module buddy_bitmap_free_coalesce
    import bbfc_pkg::*;
#(
    parameter int MAX_LAYER = 10
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         req_type,
    input  logic [LAYER_W-1:0] block_layer,
    input  logic [INDEX_W-1:0] block_index,
    output logic               done,
    output logic [LAYER_W-1:0] final_layer,
    output logic [INDEX_W-1:0] final_index,
    output logic               bit_value,
    output logic               status
);

    localparam int FLAT_W = MAX_LAYER + 1;
    localparam int ADDR_W = MAX_LAYER - 2;
    localparam int DEPTH  = 1 << ADDR_W;

    state_t              state_reg, state_next;
    req_t                req_reg, req_next;
    logic [LAYER_W-1:0]  layer_reg, layer_next;
    logic [INDEX_W-1:0]  index_reg, index_next;
    logic [ADDR_W-1:0]   clr_cnt_reg, clr_cnt_next;
    logic                done_reg, done_next;
    logic [LAYER_W-1:0]  final_layer_reg, final_layer_next;
    logic [INDEX_W-1:0]  final_index_reg, final_index_next;
    logic                bit_value_reg, bit_value_next;
    logic                status_reg, status_next;

    logic                accept;
    logic                req_ok;
    logic [FLAT_W-1:0]   flat_pos;
    logic [ADDR_W-1:0]   byte_addr;
    logic [2:0]          bit_sel;
    logic [2:0]          buddy_sel;
    logic                merge;

    logic                ram_we;
    logic [ADDR_W-1:0]   ram_waddr;
    logic [BYTE_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [BYTE_W-1:0]   ram_rdata;

    bbfc_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (DEPTH)
    ) u_bitmap (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (byte_addr),
        .rdata (ram_rdata)
    );

    assign busy   = (state_reg != ST_IDLE);
    assign accept = start && !busy;

    // layer above the tree or index past its layer is rejected
    assign req_ok = (int'(block_layer) <= MAX_LAYER) && ((block_index >> block_layer) == '0);

    // heap-style position; buddy always shares the byte since only bit 0 differs
    assign flat_pos  = (FLAT_W'(1) << layer_reg) + FLAT_W'(index_reg);
    assign byte_addr = flat_pos[FLAT_W-1:3];
    assign bit_sel   = flat_pos[2:0];
    assign buddy_sel = bit_sel ^ 3'd1;
    assign merge     = (req_reg == REQ_FREE) && (layer_reg != '0) && ram_rdata[buddy_sel];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept && req_ok)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = merge ? ST_READ : ST_IDLE;
            end
        endcase
    end

    // ram controls
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = byte_addr;
        ram_wdata = ram_rdata;
        ram_re    = 1'b0;
        unique case (state_reg)
            ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_cnt_reg;
                ram_wdata = '0;
            end
            ST_IDLE:
            begin
                ram_re = 1'b0;
            end
            ST_READ:
            begin
                ram_re = 1'b1;
            end
            ST_EVAL:
            begin
                case (req_reg)
                    REQ_FREE:
                    begin
                        ram_we = 1'b1;
                        if (merge)
                        begin
                            ram_wdata = ram_rdata & ~(BYTE_W'(1) << buddy_sel);
                        end
                        else
                        begin
                            ram_wdata = ram_rdata | (BYTE_W'(1) << bit_sel);
                        end
                    end
                    REQ_SET:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata | (BYTE_W'(1) << bit_sel);
                    end
                    REQ_CLR:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = ram_rdata & ~(BYTE_W'(1) << bit_sel);
                    end
                    REQ_TEST:
                    begin
                        ram_we = 1'b0;
                    end
                endcase
            end
        endcase
    end

    // datapath and result registers
    always_comb
    begin
        req_next         = req_reg;
        layer_next       = layer_reg;
        index_next       = index_reg;
        clr_cnt_next     = clr_cnt_reg;
        done_next        = 1'b0;
        final_layer_next = final_layer_reg;
        final_index_next = final_index_reg;
        bit_value_next   = bit_value_reg;
        status_next      = status_reg;

        if (state_reg == ST_CLEAR)
        begin
            clr_cnt_next = clr_cnt_reg + ADDR_W'(1);
        end

        if (accept)
        begin
            req_next   = req_t'(req_type);
            layer_next = block_layer;
            index_next = block_index;
            if (!req_ok)
            begin
                done_next        = 1'b1;
                final_layer_next = block_layer;
                final_index_next = block_index;
                bit_value_next   = 1'b0;
                status_next      = 1'b1;
            end
        end

        if (state_reg == ST_EVAL)
        begin
            if (merge)
            begin
                layer_next = layer_reg - LAYER_W'(1);
                index_next = index_reg >> 1;
            end
            else
            begin
                done_next        = 1'b1;
                final_layer_next = layer_reg;
                final_index_next = index_reg;
                bit_value_next   = (req_reg == REQ_TEST) ? ram_rdata[bit_sel] : 1'b0;
                status_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_CLEAR;
            clr_cnt_reg <= '0;
            done_reg    <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            done_reg    <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg         <= req_next;
        layer_reg       <= layer_next;
        index_reg       <= index_next;
        final_layer_reg <= final_layer_next;
        final_index_reg <= final_index_next;
        bit_value_reg   <= bit_value_next;
        status_reg      <= status_next;
    end

    assign done        = done_reg;
    assign final_layer = final_layer_reg;
    assign final_index = final_index_reg;
    assign bit_value   = bit_value_reg;
    assign status      = status_reg;

    `BBFC_ASSERT_NOW(a_done_when_idle, done, !busy, "result shown while busy")
    `BBFC_ASSERT_NOW(a_reject_no_bit, done && status, !bit_value, "rejected with bit set")
    `BBFC_ASSERT_NOW(a_write_states, ram_we, state_reg == ST_EVAL || state_reg == ST_CLEAR, "stray ram write")
    `BBFC_ASSERT_NEXT(a_accept_moves, start && !busy, busy || done, "accepted transaction dropped")
    `BBFC_ASSERT_NOW(a_layer_range, state_reg == ST_READ, int'(layer_reg) <= MAX_LAYER, "walk layer out of tree")

endmodule
